### rtl/lrr_pkg.sv
// Shared constants and types for the range-limited LCG random number block.
`default_nettype none
package lrr_pkg;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned BOUND_W = 17;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned STEP_W  = 4;

  localparam logic [STATE_W-1:0] LCG_MULT   = 32'd1194211693;
  localparam logic [STATE_W-1:0] LCG_ADD    = 32'd12345;
  localparam logic [STATE_W-1:0] SEED_RESET = 32'd1;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/lrr_lcg.sv
// Generator state register with its multiply-add update and seed load.
`default_nettype none
module lrr_lcg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic [lrr_pkg::STATE_W-1:0] seed,
  input  wire logic                        step,
  output logic      [lrr_pkg::STATE_W-1:0] state
);
  import lrr_pkg::*;

  logic [STATE_W-1:0] state_r;
  logic [STATE_W-1:0] state_nxt;
  logic [STATE_W-1:0] prod;

  assign prod = state_r * LCG_MULT;

  always_comb begin
    state_nxt = state_r;
    if (load) begin
      state_nxt = seed;
    end else if (step) begin
      state_nxt = prod + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule
`default_nettype wire

### rtl/lrr_div.sv
// Restoring divider that produces one remainder bit per cycle.
`default_nettype none
module lrr_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrr_pkg::div_req_t req,
  output lrr_pkg::div_rsp_t      rsp
);
  import lrr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  dvd_r;
  logic [VAL_W-1:0]  dsr_r;
  logic [VAL_W:0]    shifted;
  logic [VAL_W+1:0]  diff;

  assign shifted = {rem_r, dvd_r[VAL_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == {STEP_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= diff[VAL_W+1] ? shifted[VAL_W-1:0] : diff[VAL_W-1:0];
      dvd_r <= {dvd_r[VAL_W-2:0], 1'b0};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

### rtl/lcg_random_in_range.sv
// Top level of the range-limited LCG random number block.
// Each accepted beat advances a 32-bit generator (state = 1194211693 * state
// + 12345) and returns the upper 16 bits of the new state modulo the beat's
// upper bound. An accepted item goes through these steps in order: latch the
// bound, start the divider, sixteen divider steps, take the remainder and
// load the output register. A bound of 0 or of 65536 and above skips the
// divider and returns the upper 16 bits unchanged. The next beat is accepted
// from the cycle after the result is loaded, so no new item is taken while
// one is in flight, and a result still waiting on out_ready holds the
// following one back. Writing the seed register reloads the generator state
// at once; the state resets to 1.
`default_nettype none
module lcg_random_in_range (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lrr_pkg::STATE_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lrr_pkg::BOUND_W-1:0] in_upper_bound,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [lrr_pkg::VAL_W-1:0]   out_value
);
  import lrr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_HOLD
  } st_t;

  st_t                st_r;
  logic [BOUND_W-1:0] bound_r;
  logic [VAL_W-1:0]   res_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [STATE_W-1:0] lcg_state;
  logic [VAL_W-1:0]   upper;
  logic               bypass;
  logic               in_acc;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_ready = (st_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign upper    = lcg_state[STATE_W-1:STATE_W-VAL_W];
  assign bypass   = bound_r[BOUND_W-1] || (bound_r[VAL_W-1:0] == '0);

  assign div_req.start    = (st_r == S_START) && !bypass;
  assign div_req.dividend = upper;
  assign div_req.divisor  = bound_r[VAL_W-1:0];

  lrr_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cfg_we),
    .seed  (cfg_wdata),
    .step  (in_acc),
    .state (lcg_state)
  );

  lrr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (st_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            bound_r <= in_upper_bound;
            st_r    <= S_START;
          end
        end
        S_START: begin
          if (bypass) begin
            res_r <= upper;
            st_r  <= S_HOLD;
          end else begin
            st_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            res_r <= div_rsp.rem;
            st_r  <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_r;
            st_r        <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> lcg_state == $past(cfg_wdata))
    else $error("generator state did not take the seed");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> st_r == S_WAIT)
    else $error("divider finished outside the wait state");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> div_rsp.rem < bound_r[VAL_W-1:0])
    else $error("remainder not below the bound");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

### tb/lcg_random_in_range_test.sv
// Self-checking testbench for the range-limited LCG random number block.
`timescale 1ns / 1ps
module lcg_random_in_range_test;
  import lrr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS   = 125;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 40;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PATTERN
  } stall_mode_t;

  typedef struct packed {
    logic               reseed;
    logic [STATE_W-1:0] seed;
    logic [BOUND_W-1:0] bound;
    logic               typed;
    logic [VAL_W-1:0]   value;
  } stim_row_t;

  localparam stim_row_t DIRECTED [20] = '{
    '{1'b0, 32'h0000_0000, 17'd65536,   1'b1, 16'd18222},
    '{1'b0, 32'h0000_0000, 17'd1,       1'b1, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd0,       1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd65535,   1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd2,       1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'h1FFFF,   1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd65537,   1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd3,       1'b0, 16'd0},
    '{1'b1, 32'h0000_0000, 17'd65536,   1'b1, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd1,       1'b1, 16'd0},
    '{1'b1, 32'h0000_0000, 17'd0,       1'b1, 16'd0},
    '{1'b1, 32'hFFFF_FFFF, 17'd65536,   1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'h0AAAA,   1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'h15555,   1'b0, 16'd0},
    '{1'b1, 32'h8000_0000, 17'd12345,   1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd7,       1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd32768,   1'b0, 16'd0},
    '{1'b1, 32'hA5A5_5A5A, 17'd100,     1'b0, 16'd0},
    '{1'b0, 32'h0000_0000, 17'd1000,    1'b0, 16'd0},
    '{1'b1, 32'h0000_0001, 17'd65536,   1'b1, 16'd18222}
  };

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [STATE_W-1:0] cfg_wdata      = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [BOUND_W-1:0] in_upper_bound = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [VAL_W-1:0]   out_value;

  logic [STATE_W-1:0] seed_reg;
  logic [STATE_W-1:0] lcg_state;
  logic [VAL_W-1:0]   pending_values [$];
  int                 beats_in    = 0;
  int                 beats_out   = 0;
  int                 mismatches  = 0;
  int                 seed_writes = 0;
  int                 cycles      = 0;
  int                 burst_left;
  bit                 driving     = 1'b0;
  stall_mode_t        stall_mode  = READY_MOSTLY;

  lcg_random_in_range DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_upper_bound (in_upper_bound),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  function automatic logic [VAL_W-1:0] draw_in_range(input logic [BOUND_W-1:0] bound);
    logic [BOUND_W-1:0] upper;
    lcg_state = LCG_MULT * lcg_state + LCG_ADD;
    upper = {1'b0, lcg_state[31:16]};
    if (bound == '0) begin
      return upper[VAL_W-1:0];
    end
    return VAL_W'(upper % bound);
  endfunction

  task automatic wait_idle();
    if (driving) begin
      in_valid <= 1'b0;
      driving = 1'b0;
    end
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [STATE_W-1:0] seed);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_reg  = seed;
    lcg_state = seed_reg;
    seed_writes++;
  endtask

  task automatic send_bound(input logic [BOUND_W-1:0] bound, input logic typed,
                            input logic [VAL_W-1:0] typed_value);
    logic [VAL_W-1:0] predicted;
    in_valid       <= 1'b1;
    in_upper_bound <= bound;
    driving = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = draw_in_range(bound);
    pending_values.push_back(typed ? typed_value : predicted);
    beats_in++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid       <= 1'b0;
      in_upper_bound <= BOUND_W'($urandom);
      driving = 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  always @(posedge clk) begin
    case (stall_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= (cycles[4:2] != 3'b101);
    endcase
  end

  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_values.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("Unexpected result beat: value %0d", out_value);
        end
        mismatches++;
      end else begin
        want = pending_values.pop_front();
        if (out_value !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("Value mismatch on result %0d: expected %0d, got %0d",
                     beats_out, want, out_value);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timed out with %0d results outstanding.", pending_values.size());
    $display("lcg_random_in_range_test failed");
    $finish;
  end

  initial begin
    logic [BOUND_W-1:0] bound;
    seed_reg   = SEED_RESET;
    lcg_state  = SEED_RESET;
    burst_left = $urandom_range(1, 12);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].reseed) begin
        write_seed(DIRECTED[r].seed);
      end
      send_bound(DIRECTED[r].bound, DIRECTED[r].typed, DIRECTED[r].value);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        write_seed('0);
      end else if (p == 6) begin
        write_seed('1);
      end else begin
        write_seed(STATE_W'($urandom));
      end
      stall_mode = stall_mode_t'(p % 4);
      repeat (PHASE_BEATS) begin
        case ($urandom_range(0, 9))
          0, 1, 2: bound = BOUND_W'($urandom_range(1, 16));
          3, 4:    bound = BOUND_W'($urandom_range(1, 65536));
          5:       bound = BOUND_W'(1) << $urandom_range(0, 16);
          6:       bound = BOUND_W'(65536 - $urandom_range(0, 15));
          7:       bound = '0;
          8:       bound = BOUND_W'($urandom_range(65537, 131071));
          default: bound = BOUND_W'($urandom);
        endcase
        send_bound(bound, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drew %0d bounded values over %0d seed loads, zero and all-ones seeds included.",
             beats_in, seed_writes);
    $display("Checked %0d result beats under four receiver stall patterns; %0d mismatches.",
             beats_out, mismatches);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("lcg_random_in_range_test passed");
    end else begin
      $display("lcg_random_in_range_test failed");
    end
    $finish;
  end

endmodule
